// ===== design/masked_byte_pattern_search_macros.svh =====
// Assertion macros used by the masked byte pattern search checker.
`ifndef MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH
`define MASKED_BYTE_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MBPS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("masked byte pattern search check failed");

// Next-cycle implication, disabled during reset.
`define MBPS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("masked byte pattern search check failed");

`endif

// ===== design/mbps_pkg.sv =====
// Shared types and constants for the masked byte pattern search block.
package mbps_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam int LEN_W           = 6;
    localparam int ADDR_W          = 64;
    localparam int CFG_IDX_W       = 1;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_BREAK  = 2'd2,
        OP_DATA   = 2'd3
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 1'd0,
        REG_IGNORE_ADDRESS = 1'd1
    } cfg_reg_t;

    // Decoded action of the item being processed this cycle.
    typedef struct packed {
        logic load;
        logic start;
        logic region_brk;
        logic data;
    } op_dec_t;

endpackage

// ===== design/mbps_store.sv =====
// Pattern and mask byte stores, written by load items and read at every position.
module mbps_store
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                          aclk,
    input  op_dec_t                       dec,
    input  logic [4:0]                    entry_index,
    input  logic [7:0]                    pattern_byte,
    input  logic [7:0]                    mask_byte,
    output logic [MAX_PATTERN-1:0][7:0]   pattern_bytes,
    output logic [MAX_PATTERN-1:0][7:0]   mask_bytes
);

    logic [MAX_PATTERN-1:0][7:0] pattern_reg;
    logic [MAX_PATTERN-1:0][7:0] mask_reg;

    always_ff @(posedge aclk) begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            if (dec.load && (int'(entry_index) == j)) begin
                pattern_reg[j] <= pattern_byte;
                mask_reg[j]    <= mask_byte;
            end
        end
    end

    assign pattern_bytes = pattern_reg;
    assign mask_bytes    = mask_reg;

endmodule

// ===== design/mbps_window.sv =====
// Sliding window of recent data bytes with its fill count.
module mbps_window
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int FILL_W      = $clog2(MAX_PATTERN + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  op_dec_t                       dec,
    input  logic [7:0]                    data_byte,
    output logic [MAX_PATTERN-1:0][7:0]   win_shift,
    output logic [FILL_W-1:0]             fill_inc
);

    logic [MAX_PATTERN-1:0][7:0] win_reg;
    logic [MAX_PATTERN-1:0][7:0] win_next;
    logic [FILL_W-1:0]           fill_reg;
    logic [FILL_W-1:0]           fill_next;

    always_comb begin
        win_shift[0] = data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            win_shift[k] = win_reg[k-1];
        end
        if (int'(fill_reg) < MAX_PATTERN) begin
            fill_inc = fill_reg + FILL_W'(1);
        end else begin
            fill_inc = fill_reg;
        end
    end

    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        if (dec.start) begin
            win_next  = '0;
            fill_next = '0;
        end else if (dec.region_brk) begin
            fill_next = '0;
        end else if (dec.data) begin
            win_next  = win_shift;
            fill_next = fill_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg  <= '0;
            fill_reg <= '0;
        end else begin
            win_reg  <= win_next;
            fill_reg <= fill_next;
        end
    end

endmodule

// ===== design/mbps_compare.sv =====
// Parallel masked compare of the aligned window against all pattern positions.
module mbps_compare
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF,
    parameter int FILL_W      = $clog2(MAX_PATTERN + 1)
) (
    input  logic [MAX_PATTERN-1:0][7:0] win,
    input  logic [MAX_PATTERN-1:0][7:0] pattern_bytes,
    input  logic [MAX_PATTERN-1:0][7:0] mask_bytes,
    input  logic [FILL_W-1:0]           eff_len,
    output logic                        all_ok
);

    logic [MAX_PATTERN-1:0] pos_ok;

    // Pattern position i lines up with window slot eff_len - 1 - i.
    always_comb begin
        logic [7:0] slot_byte;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            slot_byte = '0;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                if (k + i + 1 == int'(eff_len)) begin
                    slot_byte = win[k];
                end
            end
            if (i < int'(eff_len)) begin
                pos_ok[i] = ((slot_byte ^ pattern_bytes[i]) & mask_bytes[i]) == 8'h00;
            end else begin
                pos_ok[i] = 1'b1;
            end
        end
    end

    assign all_ok = &pos_ok;

endmodule

// ===== design/masked_byte_pattern_search.sv =====
// A result is captured in the output register after its item has passed the input register.
// Throughput: one item per cycle while m_ready does not stall the output; the window compare is combinational.
// The input register refills while the result register is taken, so a stall only
// holds both stages. Reset is synchronous and active low: it clears the handshake
// state, the window, fill count and found flag and loads the configuration reset
// values. The pattern and mask stores are not reset.
module masked_byte_pattern_search
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [ADDR_W-1:0]     cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [4:0]            s_entry_index,
    input  logic [7:0]            s_pattern_byte,
    input  logic [7:0]            s_mask_byte,
    input  logic [7:0]            s_data_byte,
    input  logic [ADDR_W-1:0]     s_byte_address,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_match,
    output logic [ADDR_W-1:0]     m_match_start,
    output logic                  m_any_found
);

    localparam int FILL_W = $clog2(MAX_PATTERN + 1);

    logic                        in_valid_reg;
    op_t                         op_reg;
    logic [4:0]                  idx_reg;
    logic [7:0]                  pbyte_reg;
    logic [7:0]                  mbyte_reg;
    logic [7:0]                  dbyte_reg;
    logic [ADDR_W-1:0]           addr_reg;

    logic [LEN_W-1:0]            len_reg;
    logic [ADDR_W-1:0]           ignore_reg;
    logic                        found_reg;
    logic                        found_next;

    logic                        out_valid_reg;
    logic                        match_reg;
    logic                        match_next;
    logic [ADDR_W-1:0]           start_reg;
    logic [ADDR_W-1:0]           start_next;
    logic                        any_reg;
    logic                        any_next;

    logic                        advance;
    op_dec_t                     dec;
    logic [FILL_W-1:0]           eff_len;
    logic [FILL_W-1:0]           fill_inc;
    logic [MAX_PATTERN-1:0][7:0] win_shift;
    logic [MAX_PATTERN-1:0][7:0] pattern_bytes;
    logic [MAX_PATTERN-1:0][7:0] mask_bytes;
    logic                        all_ok;
    logic [ADDR_W-1:0]           win_start;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        dec = '0;
        case (op_reg)
            OP_LOAD:  dec.load       = advance;
            OP_START: dec.start      = advance;
            OP_BREAK: dec.region_brk = advance;
            OP_DATA:  dec.data       = advance;
            default:  dec            = '0;
        endcase
    end

    always_comb begin
        if (int'(len_reg) > MAX_PATTERN) begin
            eff_len = FILL_W'(MAX_PATTERN);
        end else begin
            eff_len = FILL_W'(len_reg);
        end
    end

    mbps_store #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_store (
        .aclk          (aclk),
        .dec           (dec),
        .entry_index   (idx_reg),
        .pattern_byte  (pbyte_reg),
        .mask_byte     (mbyte_reg),
        .pattern_bytes (pattern_bytes),
        .mask_bytes    (mask_bytes)
    );

    mbps_window #(
        .MAX_PATTERN(MAX_PATTERN),
        .FILL_W     (FILL_W)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dec       (dec),
        .data_byte (dbyte_reg),
        .win_shift (win_shift),
        .fill_inc  (fill_inc)
    );

    mbps_compare #(
        .MAX_PATTERN(MAX_PATTERN),
        .FILL_W     (FILL_W)
    ) u_compare (
        .win           (win_shift),
        .pattern_bytes (pattern_bytes),
        .mask_bytes    (mask_bytes),
        .eff_len       (eff_len),
        .all_ok        (all_ok)
    );

    assign win_start = addr_reg - ADDR_W'(eff_len) + ADDR_W'(1);

    always_comb begin
        match_next = dec.data && (eff_len != '0) && (fill_inc >= eff_len)
                     && (win_start != ignore_reg) && all_ok;
        start_next = match_next ? win_start : '0;
        if (dec.start) begin
            found_next = 1'b0;
        end else if (match_next) begin
            found_next = 1'b1;
        end else begin
            found_next = found_reg;
        end
        any_next = found_next || (eff_len == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            len_reg       <= LEN_W'(1);
            ignore_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                found_reg     <= found_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_PATTERN_LENGTH: len_reg    <= cfg_wdata[LEN_W-1:0];
                    REG_IGNORE_ADDRESS: ignore_reg <= cfg_wdata;
                    default:            len_reg    <= len_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            op_reg    <= op_t'(s_op);
            idx_reg   <= s_entry_index;
            pbyte_reg <= s_pattern_byte;
            mbyte_reg <= s_mask_byte;
            dbyte_reg <= s_data_byte;
            addr_reg  <= s_byte_address;
        end
        if (advance) begin
            match_reg <= match_next;
            start_reg <= start_next;
            any_reg   <= any_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_match       = match_reg;
    assign m_match_start = start_reg;
    assign m_any_found   = any_reg;

endmodule

// ===== design/mbps_checker.sv =====
// Port-level checks for the masked byte pattern search block, bound to the top level.
`include "masked_byte_pattern_search_macros.svh"

module mbps_checker
    import mbps_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_match,
    input logic [ADDR_W-1:0] m_match_start,
    input logic              m_any_found
);

    `MBPS_ASSERT_IMP(match_sets_found, aclk, aresetn, m_valid && m_match, m_any_found)
    `MBPS_ASSERT_IMP(no_match_zero_start, aclk, aresetn, m_valid && !m_match, m_match_start == '0)
    `MBPS_ASSERT_NXT(stalled_item_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_match) && $stable(m_match_start) && $stable(m_any_found))
    `MBPS_ASSERT_IMP(empty_output_takes_item, aclk, aresetn, !m_valid, s_ready)

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (.*);
